>>> src/rltd_pkg.sv
`default_nettype none

package rltd_pkg;

    // Run count width and its saturation point
    localparam int unsigned CNT_W = 7;
    localparam logic [CNT_W-1:0] COUNT_SAT = 7'd127;

    // Configuration register
    localparam int unsigned MAX_TOTAL_W = 7;
    localparam logic [MAX_TOTAL_W-1:0] MAX_TOTAL_RESET = 7'd50;

    // ASCII digit range
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    // Parameter defaults
    localparam int unsigned DEF_BUFFER_DEPTH = 64;
    localparam int unsigned DEF_MAX_DIGITS   = 2;

    // Result flag positions in the output tuser
    localparam int unsigned TUSER_TOO_LONG = 0;
    localparam int unsigned TUSER_EMPTY    = 1;
    localparam int unsigned TUSER_W        = 2;

endpackage : rltd_pkg

`default_nettype wire

>>> src/run_length_text_decoder.sv
`default_nettype none

// Channel   | Direction | Signals                         | Word contents
// ----------+-----------+---------------------------------+------------------------------
// s_axis    | in        | s_tvalid s_tready s_tdata       | tdata[7:0] char_in,
//           |           | s_tlast                         | tlast end_of_string
// m_axis    | out       | m_tvalid m_tready m_tdata m_tuser m_tlast
//           |           |                                 | tdata[7:0] symbol,
//           |           |                                 | tuser[0] too_long, tuser[1] empty_res,
//           |           |                                 | tlast last
// cfg       | in        | cfg_we cfg_data                 | cfg_data[6:0] max_total
//
// A digit byte, or any byte after an error, is taken in the idle state. A symbol byte with
// nonzero repeats enters the fill state, writing one buffer entry a cycle. At end of
// string each buffered result passes the load state (buffer read), then the send state
// (output register), held while m_tready is low; an error or empty result is presented
// the cycle after the final byte. Input is not taken while a string is being filled or
// sent. Reset clears all control state at once; the buffer needs no clearing.

module run_length_text_decoder
    import rltd_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = DEF_BUFFER_DEPTH,
    parameter int unsigned MAX_DIGITS   = DEF_MAX_DIGITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,   // [7:0] char_in
    input  wire logic                   s_tlast,   // end_of_string

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] symbol
    output logic [TUSER_W-1:0]          m_tuser,   // [0] too_long, [1] empty_res
    output logic                        m_tlast,   // last

    input  wire logic                   cfg_we,
    input  wire logic [MAX_TOTAL_W-1:0] cfg_data   // max_total
);

    localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int unsigned TW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned PW = TW + 1;
    localparam int unsigned SW = ((TW > CNT_W) ? TW : CNT_W) + 1;
    localparam int unsigned DW = $clog2(MAX_DIGITS + 1);
    localparam int unsigned MW = CNT_W + 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOAD,
        ST_SEND
    } state_t;

    state_t                 state_reg,   state_next;
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic [DW-1:0]          digits_reg,  digits_next;
    logic [TW-1:0]          total_reg,   total_next;
    logic                   err_reg,     err_next;
    logic                   eos_reg,     eos_next;
    logic [7:0]             fill_sym_reg, fill_sym_next;
    logic [AW-1:0]          wr_ptr_reg,  wr_ptr_next;
    logic [AW-1:0]          rd_ptr_reg,  rd_ptr_next;
    logic                   tl_reg,      tl_next;
    logic                   em_reg,      em_next;
    logic                   last_reg,    last_next;
    logic [MAX_TOTAL_W-1:0] max_total_reg;
    logic [7:0]             rd_data_reg;

    logic [7:0]             buffer_mem [BUFFER_DEPTH];

    logic                   is_digit;
    logic [MW-1:0]          count_x10;
    logic [CNT_W-1:0]       count_sat;
    logic [CNT_W-1:0]       reps;
    logic [SW-1:0]          sum;
    logic [SW-1:0]          limit;
    logic                   fill_done;
    logic                   send_done;

    // Classify the byte and build the next count value
    assign is_digit  = s_tdata inside {[CHAR_ZERO:CHAR_NINE]};
    assign count_x10 = (MW'(count_reg) << 3) + (MW'(count_reg) << 1) + MW'(s_tdata[3:0]);
    assign count_sat = (count_x10 > MW'(COUNT_SAT)) ? COUNT_SAT : count_x10[CNT_W-1:0];

    // Repeat count, running total and capped limit
    assign reps  = (digits_reg == '0) ? CNT_W'(1) : count_reg;
    assign sum   = SW'(total_reg) + SW'(reps);
    assign limit = (SW'(max_total_reg) > SW'(BUFFER_DEPTH)) ? SW'(BUFFER_DEPTH)
                                                           : SW'(max_total_reg);

    assign fill_done = (PW'(wr_ptr_reg) + PW'(1)) == PW'(total_reg);
    assign send_done = (PW'(rd_ptr_reg) + PW'(1)) == PW'(total_reg);

    // Handshake and output word
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tdata  = (tl_reg || em_reg) ? 8'd0 : rd_data_reg;
    assign m_tlast  = last_reg;
    always_comb
    begin
        m_tuser                 = '0;
        m_tuser[TUSER_TOO_LONG] = tl_reg;
        m_tuser[TUSER_EMPTY]    = em_reg;
    end

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        digits_next   = digits_reg;
        total_next    = total_reg;
        err_next      = err_reg;
        eos_next      = eos_reg;
        fill_sym_next = fill_sym_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        tl_next       = tl_reg;
        em_next       = em_reg;
        last_next     = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    eos_next = s_tlast;
                    if (!err_reg)
                    begin
                        if (is_digit)
                        begin
                            if (digits_reg >= DW'(MAX_DIGITS))
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                count_next  = count_sat;
                                digits_next = digits_reg + DW'(1);
                            end
                        end
                        else if (sum > limit)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            count_next  = '0;
                            digits_next = '0;
                            total_next  = TW'(sum);
                            if (reps != '0)
                            begin
                                wr_ptr_next   = AW'(total_reg);
                                fill_sym_next = s_tdata;
                                state_next    = ST_FILL;
                            end
                        end
                    end

                    // Start the result phase unless repeats are still to be written
                    if (s_tlast && (state_next == ST_IDLE))
                    begin
                        if (err_next)
                        begin
                            tl_next    = 1'b1;
                            em_next    = 1'b0;
                            last_next  = 1'b1;
                            state_next = ST_SEND;
                        end
                        else if (total_next == '0)
                        begin
                            tl_next    = 1'b0;
                            em_next    = 1'b1;
                            last_next  = 1'b1;
                            state_next = ST_SEND;
                        end
                        else
                        begin
                            rd_ptr_next = '0;
                            state_next  = ST_LOAD;
                        end
                    end
                end
            end

            ST_FILL:
            begin
                if (fill_done)
                begin
                    rd_ptr_next = '0;
                    state_next  = eos_reg ? ST_LOAD : ST_IDLE;
                end
                else
                begin
                    wr_ptr_next = wr_ptr_reg + AW'(1);
                end
            end

            ST_LOAD:
            begin
                tl_next    = 1'b0;
                em_next    = 1'b0;
                last_next  = send_done;
                state_next = ST_SEND;
            end

            ST_SEND:
            begin
                if (m_tready)
                begin
                    if (last_reg)
                    begin
                        count_next  = '0;
                        digits_next = '0;
                        total_next  = '0;
                        err_next    = 1'b0;
                        tl_next     = 1'b0;
                        em_next     = 1'b0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                        state_next  = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            digits_reg   <= '0;
            total_reg    <= '0;
            err_reg      <= 1'b0;
            eos_reg      <= 1'b0;
            fill_sym_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            tl_reg       <= 1'b0;
            em_reg       <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            digits_reg   <= digits_next;
            total_reg    <= total_next;
            err_reg      <= err_next;
            eos_reg      <= eos_next;
            fill_sym_reg <= fill_sym_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            tl_reg       <= tl_next;
            em_reg       <= em_next;
            last_reg     <= last_next;
        end
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg <= MAX_TOTAL_RESET;
        end
        else if (cfg_we)
        begin
            max_total_reg <= cfg_data;
        end
    end

    // Decode buffer: write one repeat per fill cycle, read one entry per load
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FILL)
        begin
            buffer_mem[wr_ptr_reg] <= fill_sym_reg;
        end
        if (state_reg == ST_LOAD)
        begin
            rd_data_reg <= buffer_mem[rd_ptr_reg];
        end
    end

    // Checks
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result word is pending");

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (PW'(wr_ptr_reg) < PW'(total_reg)))
        else $error("fill pointer beyond decoded total");

    a_flag_is_sole: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != '0)) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("error or empty result is not the sole word");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> ((total_reg == '0) && !err_reg
                                                && (count_reg == '0)))
        else $error("string state not cleared after final word");

endmodule : run_length_text_decoder

`default_nettype wire
